@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the position cursor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// spc_pkg
// Types, codes and widths shared by the sequence position cursor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  // Field widths
  localparam int OP_W       = 4;
  localparam int FRAME_W    = 8;
  localparam int ROW_W      = 8;
  localparam int CFG_W      = 9;
  localparam int RES_W      = 32;
  localparam int CFG_IDX_W  = 1;

  // Default counter width
  localparam int COUNTER_BITS_DEF = 32;

  // Remainder unit: one dividend bit per step
  localparam int DIV_STEPS = CFG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Stream widths
  localparam int IN_FIELDS_W  = OP_W + FRAME_W + ROW_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = FRAME_W + ROW_W + 4 * RES_W + 1 + FRAME_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] PATTERN_LENGTH_RST = CFG_W'(64);
  localparam logic [CFG_W-1:0] FRAME_COUNT_RST    = CFG_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 1'b1;

  // Event codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 4'd0,
    OP_STEP    = 4'd1,
    OP_SET     = 4'd2,
    OP_ROW     = 4'd3,
    OP_FRAME   = 4'd4,
    OP_CHECKED = 4'd5,
    OP_QUEUE   = 4'd6,
    OP_LOOP    = 4'd7,
    OP_JUMP    = 4'd8,
    OP_COUNT   = 4'd9,
    OP_SKIP    = 4'd10
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/spc_remainder.sv @@
// ----------------------------------------------------------------------------
// spc_remainder
// Restoring remainder unit: one dividend bit per step, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_remainder
  import spc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic             step,
  input  wire logic [CFG_W-1:0] dividend,
  input  wire logic [CFG_W-1:0] divisor,
  output logic      [CFG_W-1:0] rem,
  output logic                  last
);

  logic [CFG_W-1:0]     num;
  logic [CFG_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CFG_W:0]       trial;
  logic [CFG_W:0]       trial_sub;
  logic [CFG_W-1:0]     rem_next;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    trial     = {rem, num[CFG_W-1]};
    trial_sub = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      rem_next = trial_sub[CFG_W-1:0];
    end else begin
      rem_next = trial[CFG_W-1:0];
    end
  end

  assign last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (load) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (step) begin
      num <= {num[CFG_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/spc_ctrl.sv @@
// ----------------------------------------------------------------------------
// spc_ctrl
// Event sequencer: accept, run the remainder unit, commit the new position.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_ctrl
  import spc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_e state;
  state_e state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/spc_datapath.sv @@
// ----------------------------------------------------------------------------
// spc_datapath
// Position state, running totals, configuration and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_datapath
  import spc_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_TDATA_W-1:0]     m_tdata
);

  localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

  // Configuration
  logic [CFG_W-1:0] pattern_length;
  logic [CFG_W-1:0] frame_count;

  // Position state
  logic [FRAME_W-1:0]      position_frame;
  logic [ROW_W-1:0]        position_row;
  logic [COUNTER_BITS-1:0] row_tick_count;
  logic [COUNTER_BITS-1:0] frames_passed;
  logic [COUNTER_BITS-1:0] rows_passed;
  logic [COUNTER_BITS-1:0] ticks_passed;
  logic                    pending_valid;
  logic [FRAME_W-1:0]      pending_frame;
  logic                    loop_flag;

  logic [FRAME_W-1:0]      position_frame_next;
  logic [ROW_W-1:0]        position_row_next;
  logic [COUNTER_BITS-1:0] row_tick_count_next;
  logic [COUNTER_BITS-1:0] frames_passed_next;
  logic [COUNTER_BITS-1:0] rows_passed_next;
  logic [COUNTER_BITS-1:0] ticks_passed_next;
  logic                    pending_valid_next;
  logic [FRAME_W-1:0]      pending_frame_next;
  logic                    loop_flag_next;

  // Captured event
  op_e              op_q;
  logic [ROW_W-1:0] row_arg_q;
  logic [FRAME_W-1:0] frame_arg_q;

  // Input fields
  op_e                op_in;
  logic [FRAME_W-1:0] frame_arg_in;
  logic [ROW_W-1:0]   row_arg_in;

  // Remainder operands
  logic [CFG_W-1:0] frames_eff;
  logic [CFG_W-1:0] frame_lim;
  logic [CFG_W-1:0] offer;
  logic [CFG_W-1:0] checked_src;
  logic [CFG_W-1:0] dividend;
  logic [CFG_W-1:0] rem;
  logic             div_last;

  // Commit helpers
  logic [CFG_W-1:0] row_inc;
  logic [CFG_W-1:0] row_lim;
  logic             checked;

  // Totals widened for the 32-bit result fields
  logic [COUNTER_BITS+RES_W-1:0] tick_ext;
  logic [COUNTER_BITS+RES_W-1:0] frames_ext;
  logic [COUNTER_BITS+RES_W-1:0] rows_ext;
  logic [COUNTER_BITS+RES_W-1:0] ticks_ext;

  assign op_in        = op_e'(s_tdata[OP_W-1:0]);
  assign frame_arg_in = s_tdata[OP_W +: FRAME_W];
  assign row_arg_in   = s_tdata[OP_W+FRAME_W +: ROW_W];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PATTERN_LENGTH_RST;
      frame_count    <= FRAME_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data;
        CFG_FRAME_COUNT:    frame_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the frame that the event reduces modulo the frame count
  always_comb begin
    frames_eff = (frame_count == '0) ? CFG_W'(1) : frame_count;
    frame_lim  = frames_eff - 1'b1;
    case (op_in)
      OP_STEP, OP_SKIP: offer = {1'b0, position_frame} + 1'b1;
      default:          offer = {1'b0, frame_arg_in};
    endcase
    if (pending_valid) begin
      checked_src = {1'b0, pending_frame};
    end else if (loop_flag) begin
      checked_src = {1'b0, position_frame};
    end else begin
      checked_src = offer;
    end
    case (op_in)
      OP_FRAME: dividend = {1'b0, frame_arg_in};
      OP_JUMP: begin
        if ({1'b0, frame_arg_in} <= frame_lim) begin
          dividend = {1'b0, frame_arg_in};
        end else begin
          dividend = frame_lim;
        end
      end
      OP_STEP, OP_CHECKED, OP_SKIP: dividend = checked_src;
      default: dividend = '0;
    endcase
  end

  spc_remainder u_rem (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.load),
    .step     (cmd.step),
    .dividend (dividend),
    .divisor  (frames_eff),
    .rem      (rem),
    .last     (div_last)
  );

  // Capture the event operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q        <= op_in;
      frame_arg_q <= frame_arg_in;
      row_arg_q   <= row_arg_in;
    end
  end

  // Apply the event to the state
  always_comb begin
    position_frame_next = position_frame;
    position_row_next   = position_row;
    row_tick_count_next = row_tick_count;
    frames_passed_next  = frames_passed;
    rows_passed_next    = rows_passed;
    ticks_passed_next   = ticks_passed;
    pending_valid_next  = pending_valid;
    pending_frame_next  = pending_frame;
    loop_flag_next      = loop_flag;
    checked             = 1'b0;
    row_inc             = {1'b0, position_row} + 1'b1;
    row_lim             = (pattern_length == '0) ? '0 : pattern_length - 1'b1;

    case (op_q)
      OP_TICK: begin
        row_tick_count_next = row_tick_count + CNT_ONE;
        ticks_passed_next   = ticks_passed + CNT_ONE;
      end
      OP_STEP: begin
        if (row_inc >= pattern_length || row_inc[CFG_W-1]) begin
          position_row_next = '0;
          checked           = 1'b1;
        end else begin
          position_row_next = row_inc[ROW_W-1:0];
        end
        rows_passed_next    = rows_passed + CNT_ONE;
        row_tick_count_next = '0;
      end
      OP_SET: begin
        position_frame_next = frame_arg_q;
        position_row_next   = row_arg_q;
        row_tick_count_next = '0;
      end
      OP_ROW: begin
        position_row_next   = row_arg_q;
        rows_passed_next    = rows_passed + CNT_ONE;
        row_tick_count_next = '0;
      end
      OP_FRAME: begin
        position_frame_next = rem[FRAME_W-1:0];
        frames_passed_next  = frames_passed + CNT_ONE;
      end
      OP_CHECKED: begin
        checked = 1'b1;
      end
      OP_QUEUE: begin
        pending_frame_next = frame_arg_q;
        pending_valid_next = 1'b1;
      end
      OP_LOOP: begin
        loop_flag_next = 1'b1;
      end
      OP_JUMP: begin
        position_frame_next = rem[FRAME_W-1:0];
        frames_passed_next  = frames_passed + CNT_ONE;
        position_row_next   = '0;
        rows_passed_next    = rows_passed + CNT_ONE;
        row_tick_count_next = '0;
      end
      OP_COUNT: begin
        frames_passed_next = frames_passed + CNT_ONE;
      end
      OP_SKIP: begin
        checked = 1'b1;
        if ({1'b0, row_arg_q} <= row_lim) begin
          position_row_next = row_arg_q;
        end else begin
          position_row_next = row_lim[ROW_W-1:0];
        end
        rows_passed_next    = rows_passed + CNT_ONE;
        row_tick_count_next = '0;
      end
      default: ;
    endcase

    // Checked frame move: the queued frame, if any, is used up
    if (checked) begin
      pending_valid_next  = 1'b0;
      position_frame_next = rem[FRAME_W-1:0];
      frames_passed_next  = frames_passed + CNT_ONE;
    end
  end

  // Update the state on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      position_frame <= '0;
      position_row   <= '0;
      row_tick_count <= '0;
      frames_passed  <= '0;
      rows_passed    <= '0;
      ticks_passed   <= '0;
      pending_valid  <= 1'b0;
      pending_frame  <= '0;
      loop_flag      <= 1'b0;
    end else if (cmd.commit) begin
      position_frame <= position_frame_next;
      position_row   <= position_row_next;
      row_tick_count <= row_tick_count_next;
      frames_passed  <= frames_passed_next;
      rows_passed    <= rows_passed_next;
      ticks_passed   <= ticks_passed_next;
      pending_valid  <= pending_valid_next;
      pending_frame  <= pending_frame_next;
      loop_flag      <= loop_flag_next;
    end
  end

  assign tick_ext   = {{RES_W{1'b0}}, row_tick_count_next};
  assign frames_ext = {{RES_W{1'b0}}, frames_passed_next};
  assign rows_ext   = {{RES_W{1'b0}}, rows_passed_next};
  assign ticks_ext  = {{RES_W{1'b0}}, ticks_passed_next};

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= OUT_TDATA_W'({loop_flag_next,
                               pending_frame_next,
                               pending_valid_next,
                               ticks_ext[RES_W-1:0],
                               rows_ext[RES_W-1:0],
                               frames_ext[RES_W-1:0],
                               tick_ext[RES_W-1:0],
                               position_row_next,
                               position_frame_next});
    end
  end

  // Result valid: set on commit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign status.div_last = div_last;
  assign status.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

@@ hw/rtl/sequence_position_cursor.sv @@
// ----------------------------------------------------------------------------
// sequence_position_cursor
// Playback position tracker for a pattern sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   One event enters on the s_ channel (op, frame_arg, row_arg) and one
//   result leaves on the m_ channel holding the full state after the event.
//   rows per pattern and frames per song are written on the cfg_ port while
//   the block is idle.
// Operation:
//   An accepted event runs through the bit-serial remainder unit, which
//   reduces the frame modulo the frame count, then the commit, which
//   registers the result. A new event is taken only after the commit of
//   the previous one, once the block is back in idle.
// Reset:
//   rst clears position, totals, queued slot and loop flag; the registers
//   return to 64 rows and 1 frame. No result is pending after reset.
// Stall:
//   The result waits in the output register while m_tready is low, and the
//   next event is accepted meanwhile; its commit holds until the register
//   frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_position_cursor
  import spc_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  // Events
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // op[3:0], frame_arg[11:4], row_arg[19:12]
  // Results
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata    // cur_frame[7:0], cur_row[15:8],
                                                 // cur_tick[47:16], total_frames[79:48],
                                                 // total_rows[111:80], total_ticks[143:112],
                                                 // queued_valid[144], queued_frame[152:145],
                                                 // looping[153]
);

  cmd_t    cmd;
  status_t status;

  spc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  spc_datapath #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/spc_checker.sv @@
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks for the sequence position cursor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spc_checker
  import spc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  // Reset leaves the block ready with no result pending
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (s_tready && !m_tvalid), "not idle after reset")

  // One event at a time: no transfer in the cycle after one
  `ASSERT_CLK(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "back-to-back accept")

  // A new result appears only while an event is in progress
  `ASSERT_CLK(a_result_from_event, clk, rst, $rose(m_tvalid) |-> $past(!s_tready), "result without event")

  // A stalled result holds
  `ASSERT_CLK(a_result_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind sequence_position_cursor spc_checker u_spc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
